// ===== design/salc_pkg.sv =====
// Shared types, codes and defaults for the set-associative LRU cache model.
package salc_pkg;

    localparam int MAX_SET_BITS = 5;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 64;
    localparam int QUEUE_DEPTH  = 2;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_outcome;
    typedef logic [1:0] t_cfg_index;

    localparam t_op OP_LOAD   = 2'd0;
    localparam t_op OP_STORE  = 2'd1;
    localparam t_op OP_MODIFY = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    localparam t_outcome OUT_HIT   = 2'd0;
    localparam t_outcome OUT_FILL  = 2'd1;
    localparam t_outcome OUT_EVICT = 2'd2;

    localparam t_cfg_index CFG_SET_BITS   = 2'd0;
    localparam t_cfg_index CFG_WAYS       = 2'd1;
    localparam t_cfg_index CFG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways;
        logic [5:0] block_bits;
    } t_cfg;

endpackage

// ===== design/salc_req_if.sv =====
// Request channel: one memory access.
interface salc_req_if;
    logic           valid;
    logic           ready;
    salc_pkg::t_op  operation;
    logic [63:0]    address;

    modport source(output valid, output operation, output address, input ready);
    modport sink(input valid, input operation, input address, output ready);
endinterface

// ===== design/salc_res_if.sv =====
// Result channel: one lookup outcome with running totals.
interface salc_res_if;
    logic               valid;
    logic               ready;
    salc_pkg::t_outcome outcome;
    logic               last;
    logic [31:0]        hit_total;
    logic [31:0]        miss_total;
    logic [31:0]        eviction_total;

    modport source(output valid, output outcome, output last, output hit_total,
                   output miss_total, output eviction_total, input ready);
    modport sink(input valid, input outcome, input last, input hit_total,
                 input miss_total, input eviction_total, output ready);
endinterface

// ===== design/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/salc_front.sv =====
// Front end: accept requests, split the address into set and tag, queue lookups.
module salc_front #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS,
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    salc_req_if.sink              i_req,
    input  salc_pkg::t_cfg        i_cfg,
    input  logic                  i_pop,
    output logic                  o_head_valid,
    output logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] o_head_set,
    output logic [ADDR_BITS-1:0]  o_head_tag,
    output logic                  o_head_modify
);
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int QD    = salc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);
    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

    logic [63:0]        addr;
    logic [63:0]        shifted;
    logic [63:0]        tag_full;
    logic [3:0]         sb;
    logic [6:0]         shift;
    logic [SET_W-1:0]   set_idx;
    logic               is_lookup;
    logic               is_modify;
    logic               push;

    logic [SET_W-1:0]     r_q_set [QD];
    logic [ADDR_BITS-1:0] r_q_tag [QD];
    logic                 r_q_mod [QD];
    logic [PTR_W-1:0]     r_wptr;
    logic [PTR_W-1:0]     r_rptr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    always_comb begin
        addr    = i_req.address & ADDR_MASK;
        sb      = ({1'b0, i_cfg.set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                              : {1'b0, i_cfg.set_bits};
        shifted = addr >> i_cfg.block_bits;
        for (int i = 0; i < SET_W; i++) begin
            set_idx[i] = shifted[i] & (4'(i) < sb);
        end
        shift    = 7'(sb) + 7'(i_cfg.block_bits);
        tag_full = (shift < 7'd64) ? (addr >> shift) : 64'd0;
    end

    always_comb begin
        is_lookup = 1'b0;
        is_modify = 1'b0;
        unique case (i_req.operation) inside
            salc_pkg::OP_LOAD, salc_pkg::OP_STORE: is_lookup = 1'b1;
            salc_pkg::OP_MODIFY: begin
                is_lookup = 1'b1;
                is_modify = 1'b1;
            end
            default: is_lookup = 1'b0;
        endcase
    end

    assign i_req.ready = (r_count != CNT_W'(QD));
    assign push        = i_req.valid && i_req.ready && is_lookup;
    assign n_count     = r_count + CNT_W'(push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_set[r_wptr] <= set_idx;
            r_q_tag[r_wptr] <= tag_full[ADDR_BITS-1:0];
            r_q_mod[r_wptr] <= is_modify;
        end
    end

    assign o_head_valid  = (r_count != '0);
    assign o_head_set    = r_q_set[r_rptr];
    assign o_head_tag    = r_q_tag[r_rptr];
    assign o_head_modify = r_q_mod[r_rptr];
endmodule

// ===== design/salc_back.sv =====
// Back end: read a set, resolve hit, fill or eviction, update LRU ages and totals.
module salc_back #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS,
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  salc_pkg::t_cfg        i_cfg,
    input  logic                  i_head_valid,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] i_head_set,
    input  logic [ADDR_BITS-1:0]  i_head_tag,
    input  logic                  i_head_modify,
    output logic                  o_pop,
    salc_res_if.source            o_res
);
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_ROWS = 1 << SET_W;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = RANK_W;
    localparam int SLOT_W   = ADDR_BITS + RANK_W;
    localparam int ROW_W    = MAX_WAYS * SLOT_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_REREAD = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_BITS-1:0]  r_tag;
    logic                  r_final;
    logic [MAX_WAYS-1:0]   r_valid [NUM_ROWS];
    logic [31:0]           r_hits;
    logic [31:0]           r_misses;
    logic [31:0]           r_evicts;
    logic                  r_out_valid;
    salc_pkg::t_outcome    r_outcome;
    logic                  r_last;

    logic [SET_W-1:0]      raddr;
    logic [ROW_W-1:0]      rdata;
    logic [ROW_W-1:0]      wdata;
    logic                  fire;
    logic [4:0]            nw;
    logic [MAX_WAYS-1:0]   vrow;
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   hitv;
    logic [MAX_WAYS-1:0]   invv;
    logic [ADDR_BITS-1:0]  tags  [MAX_WAYS];
    logic [RANK_W-1:0]     ranks [MAX_WAYS];
    logic [RANK_W-1:0]     new_rank;
    logic [RANK_W-1:0]     best_rank;
    logic [RANK_W-1:0]     old_rank;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      inv_way;
    logic [WAY_W-1:0]      victim;
    logic [WAY_W-1:0]      way;
    logic                  sel_valid;
    salc_pkg::t_outcome    outcome;
    logic [MAX_WAYS-1:0]   new_vrow;

    assign fire  = (r_state == S_EVAL) && (!r_out_valid || o_res.ready);
    assign o_pop = (r_state == S_IDLE) && i_head_valid;
    assign raddr = (r_state == S_IDLE) ? i_head_set : r_set;

    salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_set),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (i_cfg.ways == 4'd0) begin
            nw = 5'd1;
        end else if ({1'b0, i_cfg.ways} > 5'(MAX_WAYS)) begin
            nw = 5'(MAX_WAYS);
        end else begin
            nw = {1'b0, i_cfg.ways};
        end
        vrow = r_valid[r_set];
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i]   = rdata[i*SLOT_W +: ADDR_BITS];
            ranks[i]  = rdata[i*SLOT_W + ADDR_BITS +: RANK_W];
            in_use[i] = 5'(i) < nw;
            hitv[i]   = in_use[i] && vrow[i] && (tags[i] == r_tag);
            invv[i]   = in_use[i] && !vrow[i];
        end
        hit_way = '0;
        inv_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hitv[i]) begin
                hit_way = WAY_W'(i);
            end
            if (invv[i]) begin
                inv_way = WAY_W'(i);
            end
        end
        victim    = '0;
        best_rank = ranks[0];
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && (ranks[i] > best_rank)) begin
                victim    = WAY_W'(i);
                best_rank = ranks[i];
            end
        end
        if (|hitv) begin
            outcome = salc_pkg::OUT_HIT;
            way     = hit_way;
        end else if (|invv) begin
            outcome = salc_pkg::OUT_FILL;
            way     = inv_way;
        end else begin
            outcome = salc_pkg::OUT_EVICT;
            way     = victim;
        end
        sel_valid = vrow[way];
        old_rank  = ranks[way];
        wdata     = rdata;
        new_vrow  = vrow;
        for (int i = 0; i < MAX_WAYS; i++) begin
            new_rank = ranks[i];
            if (WAY_W'(i) == way) begin
                new_rank    = '0;
                new_vrow[i] = 1'b1;
                wdata[i*SLOT_W +: ADDR_BITS] = r_tag;
            end else if (in_use[i] && vrow[i] && (!sel_valid || ranks[i] < old_rank)
                         && (ranks[i] < RANK_MAX)) begin
                new_rank = ranks[i] + 1'b1;
            end
            wdata[i*SLOT_W + ADDR_BITS +: RANK_W] = new_rank;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_head_valid) n_state = S_EVAL;
            S_EVAL:   if (fire) n_state = r_final ? S_IDLE : S_REREAD;
            S_REREAD: n_state = S_EVAL;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            for (int s = 0; s < NUM_ROWS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid    <= 1'b1;
                r_valid[r_set] <= new_vrow;
                if (outcome == salc_pkg::OUT_HIT) begin
                    r_hits <= r_hits + 32'(r_hits != '1);
                end else begin
                    r_misses <= r_misses + 32'(r_misses != '1);
                end
                if (outcome == salc_pkg::OUT_EVICT) begin
                    r_evicts <= r_evicts + 32'(r_evicts != '1);
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_set   <= i_head_set;
            r_tag   <= i_head_tag;
            r_final <= !i_head_modify;
        end else if (fire) begin
            r_final <= 1'b1;
        end
        if (fire) begin
            r_outcome <= outcome;
            r_last    <= r_final;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.outcome        = r_outcome;
    assign o_res.last           = r_last;
    assign o_res.hit_total      = r_hits;
    assign o_res.miss_total     = r_misses;
    assign o_res.eviction_total = r_evicts;
endmodule

// ===== design/set_assoc_cache_lru_model_top.sv =====
// Top level of the set-associative LRU cache model.
// Each request is a load, store or modify at a byte address; a modify makes two
// lookups and so two results, the second flagged last. A load or store passes
// the lookup engine as a set row read, then an evaluate and write back; a
// modify does both again, as the set row is read again after the first write. The
// front end queues up to two requests so that it keeps accepting while a lookup
// or a waiting result holds the engine. Tags and LRU ages sit in one RAM row per
// set; line valid bits are flip-flops cleared by reset, so no clearing pass is
// needed. Configuration (set bits, ways, block bits) is kept across writes and
// the cache is not flushed when it changes; write it only while idle.
module set_assoc_cache_lru_model_top #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS,
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    salc_req_if.sink              i_req,
    salc_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  salc_pkg::t_cfg_index  i_cfg_index,
    input  logic [5:0]            i_cfg_data
);
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    salc_pkg::t_cfg        r_cfg;
    logic                  head_valid;
    logic [SET_W-1:0]      head_set;
    logic [ADDR_BITS-1:0]  head_tag;
    logic                  head_modify;
    logic                  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 3'd0;
            r_cfg.ways       <= 4'd1;
            r_cfg.block_bits <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                salc_pkg::CFG_SET_BITS:   r_cfg.set_bits   <= i_cfg_data[2:0];
                salc_pkg::CFG_WAYS:       r_cfg.ways       <= i_cfg_data[3:0];
                salc_pkg::CFG_BLOCK_BITS: r_cfg.block_bits <= i_cfg_data;
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_cfg         (r_cfg),
        .i_pop         (pop),
        .o_head_valid  (head_valid),
        .o_head_set    (head_set),
        .o_head_tag    (head_tag),
        .o_head_modify (head_modify)
    );

    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head_valid  (head_valid),
        .i_head_set    (head_set),
        .i_head_tag    (head_tag),
        .i_head_modify (head_modify),
        .o_pop         (pop),
        .o_res         (o_res)
    );
endmodule
